@@ hw/rtl/pli_pkg.sv @@
`timescale 1ns / 1ps

package pli_pkg;

  localparam int WORD_W           = 32;
  localparam int POS_W            = 6;
  localparam int CAPACITY_DEFAULT = 64;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // Per-beat control broadcast to every cell of the chain.
  typedef struct packed {
    logic upd;
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/pli_cmd_if.sv @@
`timescale 1ns / 1ps

interface pli_cmd_if;
  logic                              valid;
  logic                              ready;
  pli_pkg::cmd_t                     command;
  logic [pli_pkg::POS_W-1:0]         position;
  logic signed [pli_pkg::WORD_W-1:0] new_value;

  modport source (output valid, output command, output position, output new_value,
                  input ready);
  modport sink   (input valid, input command, input position, input new_value,
                  output ready);
endinterface

@@ hw/rtl/pli_res_if.sv @@
`timescale 1ns / 1ps

interface pli_res_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [pli_pkg::WORD_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

@@ hw/rtl/pli_cell.sv @@
`timescale 1ns / 1ps

module pli_cell #(
  parameter int IW         = 7,
  parameter int CELL_INDEX = 0
) (
  input  logic                       clk,
  input  pli_pkg::cell_ctrl_t        ctrl,
  input  logic [IW-1:0]              idx,
  input  logic [pli_pkg::WORD_W-1:0] value,
  input  logic [pli_pkg::WORD_W-1:0] left_word,
  input  logic [pli_pkg::WORD_W-1:0] right_word,
  output logic [pli_pkg::WORD_W-1:0] word,
  output logic [pli_pkg::WORD_W-1:0] sel_word
);
  import pli_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

  logic [WORD_W-1:0] word_next;
  logic              hit;
  logic              above;

  assign hit   = (idx == MY_IDX);
  assign above = (idx < MY_IDX);

  always_comb begin
    word_next = word;
    priority if (ctrl.upd && hit) begin
      word_next = value;
    end else if (ctrl.ins && hit) begin
      word_next = value;
    end else if (ctrl.ins && above) begin
      word_next = left_word;
    end else if (ctrl.rem && (hit || above)) begin
      word_next = right_word;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign sel_word = hit ? word : '0;

endmodule

@@ hw/rtl/positional_list_insert_delete.sv @@
`timescale 1ns / 1ps

// Ordered list of signed 32-bit words kept in a row of CAPACITY cells plus an
// element count. Every command (read, update, insert, remove) finishes in the
// cycle it is accepted: all cells shift or load in parallel, and the word at
// the addressed position is picked from the cells into a result register.
// One beat is taken per cycle; the input stalls only while a result is still
// waiting in that register and the sink is not taking it. Read and remove
// always return one beat, update returns one only when the position is at or
// past the end, and insert returns none. An insert into a full list is
// dropped, and an insert at or past the end appends.
module positional_list_insert_delete #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  pli_cmd_if.sink          req,
  pli_res_if.source        rsp
);
  import pli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     count_ext;
  logic [IW-1:0]     pos_ext;
  logic [IW-1:0]     eff_idx;
  logic              in_range;
  logic              full;
  logic              accept;
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0] words [CAPACITY];
  logic [WORD_W-1:0] sel_words [CAPACITY];
  logic [WORD_W-1:0] picked;

  logic              rsp_valid;
  logic              found_q;
  logic [WORD_W-1:0] value_q;
  logic              emit;
  logic              emit_found;

  assign count_ext = IW'(count);
  assign pos_ext   = IW'(req.position);
  assign in_range  = (pos_ext < count_ext);
  assign full      = (count == CAP_C);
  assign accept    = req.valid && req.ready;

  assign req.ready = !rsp_valid || rsp.ready;

  // Appends address the slot just past the end.
  assign eff_idx = (req.command == CMD_INSERT && !in_range) ? count_ext : pos_ext;

  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (req.command)
        CMD_READ:   ctrl = '0;
        CMD_UPDATE: ctrl.upd = in_range;
        CMD_INSERT: ctrl.ins = !full;
        CMD_REMOVE: ctrl.rem = in_range;
        default:    ctrl = '0;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    pli_cell #(
      .IW         (IW),
      .CELL_INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (eff_idx),
      .value      (req.new_value),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .sel_word   (sel_words[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      picked = picked | sel_words[k];
    end
  end

  always_comb begin
    emit       = 1'b0;
    emit_found = 1'b0;
    unique case (req.command)
      CMD_READ: begin
        emit       = 1'b1;
        emit_found = in_range;
      end
      CMD_UPDATE: begin
        emit       = !in_range;
        emit_found = 1'b0;
      end
      CMD_INSERT: begin
        emit       = 1'b0;
        emit_found = 1'b0;
      end
      CMD_REMOVE: begin
        emit       = 1'b1;
        emit_found = in_range;
      end
      default: begin
        emit       = 1'b0;
        emit_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      found_q <= emit_found;
      value_q <= emit_found ? picked : '0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.found      = found_q;
  assign rsp.read_value = value_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("element count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_INSERT && !full) |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_REMOVE && in_range) |=> count == CW'($past(count) - 1'b1))
    else $error("remove did not shrink the list");

  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && req.command == CMD_READ) |=> rsp.valid)
    else $error("read produced no result beat");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> rsp.read_value == '0)
    else $error("miss beat carries a nonzero word");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pli_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEFAULT;

  typedef struct {
    logic                     found;
    logic signed [WORD_W-1:0] word;
  } lookup_t;

  // Shadow copy of the list: applies each accepted command and queues the
  // beat the block should return for it.
  class list_shadow;
    logic signed [WORD_W-1:0] words [LIST_DEPTH];
    int unsigned count;
    lookup_t     pending [$];
    int unsigned cmd_seen [4];
    int unsigned mismatches, checked, full_drops, peak_count;

    function new();
      foreach (words[i]) words[i] = '0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      count = 0;
      mismatches = 0;
      checked = 0;
      full_drops = 0;
      peak_count = 0;
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function void apply_command(input cmd_t cmd, input logic [POS_W-1:0] pos,
                                input logic signed [WORD_W-1:0] val);
      lookup_t miss;
      lookup_t hit;
      int      k;
      miss.found = 1'b0;
      miss.word  = '0;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_READ: begin
          if (pos < count) begin
            hit.found = 1'b1;
            hit.word  = words[pos];
            pending.push_back(hit);
          end else begin
            pending.push_back(miss);
          end
        end
        CMD_UPDATE: begin
          if (pos < count) words[pos] = val;
          else pending.push_back(miss);
        end
        CMD_INSERT: begin
          if (count >= LIST_DEPTH) begin
            full_drops++;
          end else begin
            // An index at or past the end appends; otherwise shift the tail up.
            for (k = count; k > pos; k--) words[k] = words[k-1];
            words[(pos < count) ? pos : count] = val;
            count++;
            if (count > peak_count) peak_count = count;
          end
        end
        CMD_REMOVE: begin
          if (pos >= count) begin
            pending.push_back(miss);
          end else begin
            hit.found = 1'b1;
            hit.word  = words[pos];
            for (k = pos; k + 1 < count; k++) words[k] = words[k+1];
            count--;
            words[count] = '0;
            pending.push_back(hit);
          end
        end
      endcase
    endfunction

    task check_lookup(input logic found, input logic signed [WORD_W-1:0] value);
      lookup_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat (found %0b, value %0d) with nothing expected",
                                  found, value));
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (found !== exp.found)
        report_mismatch($sformatf("found %0b, expected %0b", found, exp.found));
      if (value !== exp.word)
        report_mismatch($sformatf("read_value %0d, expected %0d", value, exp.word));
    endtask
  endclass

  logic clk;
  logic rst;

  pli_cmd_if req_if ();
  pli_res_if rsp_if ();

  list_shadow shadow = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int items_sent;

  positional_list_insert_delete uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("positional_list_insert_delete verification failed");
    $finish;
  end

  // Result side: ready is redrawn every cycle unless a long hold-off is running.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        shadow.check_lookup(rsp_if.found, rsp_if.read_value);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_command(input cmd_t cmd, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid     = 1'b1;
    req_if.command   = cmd;
    req_if.position  = pos;
    req_if.new_value = val;
    do @(posedge clk); while (!req_if.ready);
    shadow.apply_command(cmd, pos, val);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int insert_pct, input int remove_pct);
    cmd_t             cmd;
    logic [POS_W-1:0] pos;
    int               roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) cmd = CMD_INSERT;
    else if (roll < insert_pct + remove_pct) cmd = CMD_REMOVE;
    else if (roll[0]) cmd = CMD_READ;
    else cmd = CMD_UPDATE;
    // Mostly aim inside the list so hits dominate; the rest lands anywhere.
    if (shadow.count > 0 && $urandom_range(0, 3) != 0)
      pos = POS_W'($urandom_range(0, shadow.count - 1));
    else
      pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    send_command(cmd, pos, $urandom);
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    req_if.valid = 1'b0;
    while (shadow.pending.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int phase;
    int n;
    int ins_pct;
    int rem_pct;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.command   = CMD_READ;
    req_if.position  = '0;
    req_if.new_value = '0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    hold_left        = 0;
    items_sent       = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, appends and shifting inserts, edge values, misses.
    send_command(CMD_READ,   6'd0,  32'sd0);
    send_command(CMD_READ,   6'd63, 32'sd0);
    send_command(CMD_UPDATE, 6'd0,  -32'sd1);
    send_command(CMD_REMOVE, 6'd5,  32'sd0);
    send_command(CMD_INSERT, 6'd0,  32'sh7fffffff);
    send_command(CMD_INSERT, 6'd63, 32'sh80000000);
    send_command(CMD_INSERT, 6'd0,  32'sd0);
    send_command(CMD_INSERT, 6'd1,  -32'sd1);
    send_command(CMD_INSERT, 6'd3,  32'sh5a5a5a5a);
    for (n = 0; n < 6; n++) send_command(CMD_READ, POS_W'(n), 32'sd0);
    send_command(CMD_UPDATE, 6'd2,  32'sh80000000);
    send_command(CMD_UPDATE, 6'd40, 32'sh7fffffff);
    send_command(CMD_READ,   6'd2,  32'sd0);
    send_command(CMD_REMOVE, 6'd2,  32'sd0);
    send_command(CMD_REMOVE, 6'd0,  32'sd0);
    send_command(CMD_REMOVE, 6'd63, 32'sd0);
    send_command(CMD_REMOVE, 6'd2,  32'sd0);
    send_command(CMD_READ,   6'd0,  32'sd0);
    wait_for_results();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 49;
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 0) hold_left = 400;
      for (n = 0; n < 620; n++) begin
        // Segments of 150 beats alternate growth, churn and shrinkage so the
        // list sweeps between empty and full.
        case ((n / 150) % 4)
          0: begin
            ins_pct = 70;
            rem_pct = 10;
          end
          2: begin
            ins_pct = 10;
            rem_pct = 70;
          end
          default: begin
            ins_pct = 30;
            rem_pct = 30;
          end
        endcase
        send_random(ins_pct, rem_pct);
        if (phase == 1 && n == 300) wait_for_results();
      end
      if (phase == 2) begin
        while (shadow.count < LIST_DEPTH)
          send_command(CMD_INSERT, POS_W'($urandom_range(0, 63)), $urandom);
        repeat (4) send_command(CMD_INSERT, POS_W'($urandom_range(0, 63)), $urandom);
        for (n = 0; n < LIST_DEPTH; n++) send_command(CMD_READ, POS_W'(n), $urandom);
      end
      wait_for_results();
    end

    if (shadow.pending.size() != 0)
      shadow.report_mismatch($sformatf("%0d expected results never arrived",
                                       shadow.pending.size()));
    $display("Sent %0d commands: %0d reads, %0d updates, %0d inserts, %0d removes; %0d results checked.",
             items_sent, shadow.cmd_seen[CMD_READ], shadow.cmd_seen[CMD_UPDATE],
             shadow.cmd_seen[CMD_INSERT], shadow.cmd_seen[CMD_REMOVE], shadow.checked);
    $display("List reached %0d entries, %0d inserts dropped while full, %0d mismatches.",
             shadow.peak_count, shadow.full_drops, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("positional_list_insert_delete verification clean");
    end else begin
      $display("positional_list_insert_delete verification failed");
    end
    $finish;
  end

endmodule
